// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion helpers
// expects clk_i and rst_ni in the scope of use
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/nnroc_pkg.sv =====
// ----------------------------------------------------------------------------
// nnroc_pkg
// widths, constants and control types of the rate of change unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nnroc_pkg;

  localparam int MetricW   = 48;
  localparam int TimeW     = 63;
  localparam int IntervalW = 64;
  localparam int FracW     = 16;
  localparam int ChunkW    = 16;
  localparam int NumChunks = IntervalW / ChunkW;
  localparam int ChunkIdxW = $clog2(NumChunks);
  localparam int PartW     = MetricW + ChunkW;
  localparam int ProdW     = MetricW + IntervalW;
  localparam int HiW       = ProdW - FracW - MetricW;
  localparam int CmpW      = (HiW > TimeW) ? HiW : TimeW;
  localparam int CntW      = $clog2(MetricW);
  localparam int InDataW   = ((MetricW + TimeW + 7) / 8) * 8;
  localparam int OutDataW  = ((MetricW + 7) / 8) * 8;

  localparam logic [IntervalW-1:0] IntervalReset = IntervalW'(65536);

  typedef struct packed {
    logic                 load_in;
    logic                 mul_load;
    logic                 acc_add;
    logic [ChunkIdxW-1:0] chunk_sel;
    logic                 div_init;
    logic                 div_step;
    logic                 out_load;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic sat_hit;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/nnroc_ctrl.sv =====
// ----------------------------------------------------------------------------
// nnroc_ctrl
// sequencer for multiply, saturation check, division and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nnroc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nnroc_pkg::sts_t   sts_i,
  output nnroc_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StCheck,
    StDiv,
    StFinish
  } state_e;

  state_e                       state_q;
  logic [nnroc_pkg::CntW-1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          cnt_q <= '0;
          if (in_valid_i) begin
            state_q <= StMul;
          end
        end
        StMul: begin
          if (cnt_q == '0 && sts_i.trivial) begin
            state_q <= StFinish;
          end else if (cnt_q == nnroc_pkg::CntW'(nnroc_pkg::NumChunks)) begin
            state_q <= StCheck;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StCheck: begin
          cnt_q <= '0;
          state_q <= sts_i.sat_hit ? StFinish : StDiv;
        end
        StDiv: begin
          if (cnt_q == nnroc_pkg::CntW'(nnroc_pkg::MetricW - 1)) begin
            state_q <= StFinish;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StFinish: begin
          if (sts_i.out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.chunk_sel = nnroc_pkg::ChunkIdxW'(nnroc_pkg::NumChunks - 1)
                      - cnt_q[nnroc_pkg::ChunkIdxW-1:0];
    in_ready_o      = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      StMul: begin
        cmd_o.mul_load = (cnt_q < nnroc_pkg::CntW'(nnroc_pkg::NumChunks));
        cmd_o.acc_add  = (cnt_q != '0);
      end
      StCheck: begin
        cmd_o.div_init = 1'b1;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
      end
      StFinish: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/nnroc_dp.sv =====
// ----------------------------------------------------------------------------
// nnroc_dp
// sample history, chunked multiplier, restoring divider and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nnroc_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nnroc_pkg::cmd_t                 cmd_i,
  output nnroc_pkg::sts_t                 sts_o,
  input  logic [nnroc_pkg::InDataW-1:0]   in_data_i,
  input  logic                            in_first_i,
  input  logic                            cfg_valid_i,
  input  logic [nnroc_pkg::IntervalW-1:0] cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [nnroc_pkg::OutDataW-1:0]  out_data_o,
  output logic                            out_sat_o
);

  localparam int MW = nnroc_pkg::MetricW;
  localparam int TW = nnroc_pkg::TimeW;

  logic [nnroc_pkg::IntervalW-1:0] interval_q;
  logic [MW-1:0]                   last_metric_q;
  logic [TW-1:0]                   last_time_q;

  logic [MW-1:0]                   diff_q;
  logic [TW-1:0]                   elapsed_q;
  logic                            trivial_q;
  logic                            sat_q;
  logic [nnroc_pkg::PartW-1:0]     part_q;
  logic [nnroc_pkg::ProdW-1:0]     acc_q;
  logic [TW-1:0]                   rem_q;
  logic [MW-1:0]                   quo_q;

  logic                            out_valid_q;
  logic [MW-1:0]                   out_rate_q;
  logic                            out_sat_q;

  logic [MW-1:0]                   cur_metric;
  logic [TW-1:0]                   cur_time;
  logic                            rising;
  logic                            later;
  logic [nnroc_pkg::ChunkW-1:0]    chunk;
  logic [nnroc_pkg::HiW-1:0]       num_hi;
  logic [nnroc_pkg::CmpW-1:0]      num_hi_ext;
  logic [nnroc_pkg::CmpW-1:0]      elapsed_ext;
  logic [TW:0]                     shifted;
  logic [TW:0]                     reduced;
  logic                            ge;

  assign cur_metric  = in_data_i[MW-1:0];
  assign cur_time    = in_data_i[MW +: TW];
  assign rising      = $signed(cur_metric) > $signed(last_metric_q);
  assign later       = cur_time > last_time_q;
  assign chunk       = interval_q[cmd_i.chunk_sel * nnroc_pkg::ChunkW +: nnroc_pkg::ChunkW];
  assign num_hi      = acc_q[nnroc_pkg::ProdW-1 -: nnroc_pkg::HiW];
  assign num_hi_ext  = nnroc_pkg::CmpW'(num_hi);
  assign elapsed_ext = nnroc_pkg::CmpW'(elapsed_q);
  assign shifted     = {rem_q, quo_q[MW-1]};
  assign reduced     = shifted - {1'b0, elapsed_q};
  assign ge          = shifted >= {1'b0, elapsed_q};

  assign sts_o.trivial  = trivial_q;
  assign sts_o.sat_hit  = num_hi_ext >= elapsed_ext;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // control and history state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q    <= nnroc_pkg::IntervalReset;
      last_metric_q <= '0;
      last_time_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        interval_q <= cfg_data_i;
      end
      if (cmd_i.load_in) begin
        last_metric_q <= cur_metric;
        last_time_q   <= cur_time;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      diff_q    <= cur_metric - last_metric_q;
      elapsed_q <= cur_time - last_time_q;
      trivial_q <= in_first_i || !rising || !later;
      acc_q     <= '0;
    end
    if (cmd_i.mul_load) begin
      part_q <= diff_q * chunk;
    end
    if (cmd_i.acc_add) begin
      acc_q <= (acc_q << nnroc_pkg::ChunkW) + nnroc_pkg::ProdW'(part_q);
    end
    if (cmd_i.div_init) begin
      sat_q <= sts_o.sat_hit;
      rem_q <= num_hi_ext[TW-1:0];
      quo_q <= acc_q[nnroc_pkg::FracW +: MW];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? reduced[TW-1:0] : shifted[TW-1:0];
      quo_q <= {quo_q[MW-2:0], ge};
    end
    if (cmd_i.out_load) begin
      if (trivial_q) begin
        out_rate_q <= '0;
        out_sat_q  <= 1'b0;
      end else if (sat_q) begin
        out_rate_q <= '1;
        out_sat_q  <= 1'b1;
      end else begin
        out_rate_q <= quo_q;
        out_sat_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = nnroc_pkg::OutDataW'(out_rate_q);
  assign out_sat_o   = out_sat_q;

  `ASSERT_IMPL(a_rem_below_divisor, cmd_i.div_step, rem_q < elapsed_q)
  `ASSERT_IMPL(a_divisor_nonzero, cmd_i.div_init, elapsed_q != '0)
  `ASSERT_IMPL(a_no_overwrite, cmd_i.out_load, !out_valid_q || out_ready_i)
  `ASSERT_NEXT(a_result_shown, cmd_i.out_load, out_valid_q)

endmodule

// ===== hdl/non_negative_rate_of_change_unit.sv =====
// ----------------------------------------------------------------------------
// non_negative_rate_of_change_unit
// Samples enter on the s_axis channel: tdata holds the signed metric (16
// fraction bits) and the timestamp in ticks, tuser the first-row flag.
// Each sample yields one result on m_axis: tdata the unsigned rate per
// interval (16 fraction bits), tuser the saturation flag.
// The interval register (unsigned, 16 fraction bits) is written on the cfg
// channel, which is always ready; write it only while the unit is idle.
// A rising sample runs from transfer to next ready through the 48x16 partial
// products, one saturation check, the one-bit-per-cycle restoring divider
// and the load of the output register, whose tvalid rises with its data.
// Saturating samples skip the divider; samples forced to zero skip both the
// multiplier and the divider.
// The result register lets a new sample be taken while a result waits;
// a stalled receiver holds the unit only once the next result is finished.
// Reset clears the history (metric 0, time 0), sets the interval to 1.0
// and drops any pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module non_negative_rate_of_change_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // metric_value, sample_time, zero pad
  input  logic [nnroc_pkg::InDataW-1:0]   s_axis_tdata,
  // first_row
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // rate_value
  output logic [nnroc_pkg::OutDataW-1:0]  m_axis_tdata,
  // rate_saturated
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nnroc_pkg::IntervalW-1:0] cfg_data_i
);

  nnroc_pkg::cmd_t cmd;
  nnroc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  nnroc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nnroc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_first_i  (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_sat_o   (m_axis_tuser)
  );

endmodule
